>>> rtl/button_gesture_classifier_defines.svh
// ---------------------------------------------------------------------------
// Button gesture classifier assertion macros
// Shared concurrent assertion wrappers clocked on the block clock.
// ---------------------------------------------------------------------------
`ifndef BUTTON_GESTURE_CLASSIFIER_DEFINES_SVH
`define BUTTON_GESTURE_CLASSIFIER_DEFINES_SVH

// Check that is held off while reset is high.
`define BGC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check that also runs through reset.
`define BGC_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> rtl/bgc_pkg.sv
// ---------------------------------------------------------------------------
// Button gesture classifier package
// Widths, register indexes, reset values and event codes.
// ---------------------------------------------------------------------------
package bgc_pkg;

   localparam int TIME_WIDTH = 16;
   localparam int CMP_WIDTH  = (TIME_WIDTH > 16) ? TIME_WIDTH : 16;

   typedef logic [TIME_WIDTH-1:0] time_type;
   typedef logic [CMP_WIDTH-1:0]  cmp_type;

   localparam time_type TIME_MAX = {TIME_WIDTH{1'b1}};

   localparam int SETTLE_WIDTH = 8;
   localparam int THRESH_WIDTH = 16;
   localparam int CSR_IDX_WIDTH  = 3;
   localparam int CSR_DATA_WIDTH = 16;

   typedef logic [SETTLE_WIDTH-1:0] settle_type;
   typedef logic [THRESH_WIDTH-1:0] thresh_type;

   // register indexes
   localparam logic [CSR_IDX_WIDTH-1:0] REG_SETTLE_MS       = 3'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_DOUBLE_CLICK_MS = 3'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_HOLD_SHORT_MS   = 3'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_HOLD_MID_MS     = 3'd3;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_HOLD_LONG_MS    = 3'd4;

   // reset values
   localparam settle_type RST_SETTLE_MS       = 8'd20;
   localparam thresh_type RST_DOUBLE_CLICK_MS = 16'd300;
   localparam thresh_type RST_HOLD_SHORT_MS   = 16'd3000;
   localparam thresh_type RST_HOLD_MID_MS     = 16'd5000;
   localparam thresh_type RST_HOLD_LONG_MS    = 16'd10000;

   // event codes
   localparam logic [1:0] CLICK_NONE   = 2'd0;
   localparam logic [1:0] CLICK_SINGLE = 2'd1;
   localparam logic [1:0] CLICK_DOUBLE = 2'd2;

   localparam logic [1:0] HOLD_NONE  = 2'd0;
   localparam logic [1:0] HOLD_SHORT = 2'd1;
   localparam logic [1:0] HOLD_MID   = 2'd2;
   localparam logic [1:0] HOLD_LONG  = 2'd3;

   localparam logic [1:0] CLICKS_MAX = 2'd3;

   // raw pin levels (active low)
   localparam logic LEVEL_PRESSED  = 1'b0;
   localparam logic LEVEL_RELEASED = 1'b1;

endpackage

>>> rtl/button_gesture_classifier.sv
// ---------------------------------------------------------------------------
// Button gesture classifier
// Debounces an active-low button sampled once per tick and reports single
// click, double click and three grades of long hold.
// ---------------------------------------------------------------------------
//   channel  | dir | handshake          | payload
//   req_     | in  | tvalid/tready      | tdata[0] button_level
//   rsp_     | out | tvalid/tready      | tdata[1:0] click_event, [3:2] hold_event
//   csr_     | in  | csr_we, no wait    | csr_index, csr_wdata
//
// Every request is one tick and yields exactly one response in the next cycle.
// The state update and the result register load happen at the same edge, so a
// request can be taken every cycle unless stalled; the response register is the only stage.
// A stalled response blocks new requests only while it is still waiting.
// Synchronous reset restores state and settings to reset values; event registers are not reset.
// ---------------------------------------------------------------------------
`include "button_gesture_classifier_defines.svh"

module button_gesture_classifier
   import bgc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [7:0]                req_tdata,   // [0] button_level

   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [7:0]                rsp_tdata,   // [1:0] click_event, [3:2] hold_event

   input  logic                      csr_we,
   input  logic [CSR_IDX_WIDTH-1:0]  csr_index,
   input  logic [CSR_DATA_WIDTH-1:0] csr_wdata
);

   // configuration
   settle_type settle_ms_ff;
   thresh_type double_click_ms_ff, hold_short_ms_ff, hold_mid_ms_ff, hold_long_ms_ff;

   // tick state
   logic       prev_raw_ff, prev_raw_in;
   logic       settling_ff, settling_in;
   settle_type settle_count_ff, settle_count_in;
   logic       held_ff, held_in;
   time_type   press_ticks_ff, press_ticks_in;
   logic [1:0] clicks_ff, clicks_in;
   logic       window_running_ff, window_running_in;
   time_type   window_count_ff, window_count_in;

   // response register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] click_ev_ff, click_ev_in;
   logic [1:0] hold_ev_ff, hold_ev_in;

   logic       accept;
   logic       level;
   time_type   win_inc;
   logic       expire;
   logic [1:0] clicks_mid;
   logic       start_settle;
   logic       settle_live;
   settle_type settle_cnt_eff;
   time_type   press_inc;
   cmp_type    press_cmp;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign level      = req_tdata[0];

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, hold_ev_ff, click_ev_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ms_ff       <= RST_SETTLE_MS;
         double_click_ms_ff <= RST_DOUBLE_CLICK_MS;
         hold_short_ms_ff   <= RST_HOLD_SHORT_MS;
         hold_mid_ms_ff     <= RST_HOLD_MID_MS;
         hold_long_ms_ff    <= RST_HOLD_LONG_MS;
      end else if (csr_we) begin
         case (csr_index)
            REG_SETTLE_MS:       settle_ms_ff       <= csr_wdata[SETTLE_WIDTH-1:0];
            REG_DOUBLE_CLICK_MS: double_click_ms_ff <= csr_wdata[THRESH_WIDTH-1:0];
            REG_HOLD_SHORT_MS:   hold_short_ms_ff   <= csr_wdata[THRESH_WIDTH-1:0];
            REG_HOLD_MID_MS:     hold_mid_ms_ff     <= csr_wdata[THRESH_WIDTH-1:0];
            REG_HOLD_LONG_MS:    hold_long_ms_ff    <= csr_wdata[THRESH_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prev_raw_in       = prev_raw_ff;
      settling_in       = settling_ff;
      settle_count_in   = settle_count_ff;
      held_in           = held_ff;
      press_ticks_in    = press_ticks_ff;
      clicks_in         = clicks_ff;
      window_running_in = window_running_ff;
      window_count_in   = window_count_ff;
      click_ev_in       = click_ev_ff;
      hold_ev_in        = hold_ev_ff;
      rsp_valid_in      = rsp_valid_ff;

      // double-click window, handled first
      win_inc = (window_count_ff == TIME_MAX) ? TIME_MAX : window_count_ff + 1'b1;
      expire  = window_running_ff &&
                ((cmp_type'(win_inc) >= cmp_type'(double_click_ms_ff)) ||
                 (win_inc == TIME_MAX));
      clicks_mid = expire ? 2'd0 : clicks_ff;

      // press duration
      press_inc = (!held_ff || press_ticks_ff == TIME_MAX) ? press_ticks_ff
                                                            : press_ticks_ff + 1'b1;
      press_cmp = cmp_type'(press_inc);

      // raw edge opens the settle wait
      start_settle   = !settling_ff && (level != prev_raw_ff);
      settle_live    = settling_ff || start_settle;
      settle_cnt_eff = start_settle ? '0 : settle_count_ff;

      if (rsp_tready)
         rsp_valid_in = 1'b0;

      if (accept) begin
         rsp_valid_in = 1'b1;
         click_ev_in  = CLICK_NONE;
         hold_ev_in   = HOLD_NONE;

         window_count_in   = window_running_ff ? win_inc : window_count_ff;
         clicks_in         = clicks_mid;
         window_running_in = window_running_ff && !expire;
         if (expire) begin
            if (clicks_ff == 2'd1)
               click_ev_in = CLICK_SINGLE;
            else if (clicks_ff != 2'd0)
               click_ev_in = CLICK_DOUBLE;
         end

         press_ticks_in  = press_inc;
         prev_raw_in     = level;
         settling_in     = settle_live;
         settle_count_in = settle_cnt_eff;

         if (settle_live) begin
            if (settle_cnt_eff >= settle_ms_ff) begin
               settling_in = 1'b0;
               if (level == LEVEL_PRESSED && !held_ff) begin
                  held_in        = 1'b1;
                  press_ticks_in = '0;
               end else if (level == LEVEL_RELEASED && held_ff) begin
                  held_in = 1'b0;
                  if (press_cmp >= cmp_type'(hold_long_ms_ff))
                     hold_ev_in = HOLD_LONG;
                  else if (press_cmp >= cmp_type'(hold_mid_ms_ff))
                     hold_ev_in = HOLD_MID;
                  else if (press_cmp >= cmp_type'(hold_short_ms_ff))
                     hold_ev_in = HOLD_SHORT;
                  else begin
                     // short press: count it and reopen the window
                     if (clicks_mid != CLICKS_MAX)
                        clicks_in = clicks_mid + 2'd1;
                     window_running_in = 1'b1;
                     window_count_in   = '0;
                  end
               end
            end else begin
               settle_count_in = settle_cnt_eff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_raw_ff       <= LEVEL_RELEASED;
         settling_ff       <= 1'b0;
         settle_count_ff   <= '0;
         held_ff           <= 1'b0;
         press_ticks_ff    <= '0;
         clicks_ff         <= 2'd0;
         window_running_ff <= 1'b0;
         window_count_ff   <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         prev_raw_ff       <= prev_raw_in;
         settling_ff       <= settling_in;
         settle_count_ff   <= settle_count_in;
         held_ff           <= held_in;
         press_ticks_ff    <= press_ticks_in;
         clicks_ff         <= clicks_in;
         window_running_ff <= window_running_in;
         window_count_ff   <= window_count_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      click_ev_ff <= click_ev_in;
      hold_ev_ff  <= hold_ev_in;
   end

   `BGC_ASSERT(a_accept_gives_rsp, accept |=> rsp_valid_ff, "request without response")
   `BGC_ASSERT(a_hold_ends_press,
               (accept && hold_ev_in != HOLD_NONE) |=> !held_ff,
               "hold event while still held")
   `BGC_ASSERT(a_window_has_clicks, window_running_ff |-> (clicks_ff != 2'd0), "window open with no clicks")
   `BGC_ASSERT(a_click_code, rsp_valid_ff |-> (click_ev_ff != 2'd3), "bad click code")
   `BGC_ASSERT_ALWAYS(a_reset_idle,
                      reset |=> (!rsp_valid_ff && !held_ff && !window_running_ff),
                      "state not cleared by reset")

endmodule
